[rtl/unicycle_pose_integrator_assert.svh]
// Assertion macros shared by the pose integrator RTL.
`ifndef UNICYCLE_POSE_INTEGRATOR_ASSERT_SVH
`define UNICYCLE_POSE_INTEGRATOR_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define UPI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every clock edge outside reset.
`define UPI_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error(msg);

`endif

[rtl/upi_pkg.sv]
// Shared widths and sideband types of the pose integrator pipeline.
`default_nettype none
package upi_pkg;
	localparam int ANG_W        = 38;
	localparam int Z_W          = 33;
	localparam int XY_W         = 33;
	localparam int DIST_W       = 33;
	localparam int DEN_W        = 21;
	localparam int NUM_W        = 44;
	localparam int DS_W         = 28;
	localparam int CORDIC_STEPS = 30;

	typedef struct packed {
		logic signed [31:0]       x0;
		logic signed [31:0]       y0;
		logic signed [15:0]       h;
		logic signed [23:0]       v;
		logic [DEN_W-1:0]         aw;
		logic                     w_neg;
		logic                     straight;
		logic signed [DIST_W-1:0] travel;
		logic signed [15:0]       heading_arc;
	} trig_tag_t;

	typedef struct packed {
		logic signed [31:0]     x0;
		logic signed [31:0]     y0;
		logic signed [15:0]     h;
		logic signed [15:0]     heading_arc;
		logic                   straight;
		logic signed [DS_W-1:0] dxs;
		logic signed [DS_W-1:0] dys;
		logic                   neg_x;
		logic                   neg_y;
	} div_tag_t;
endpackage
`default_nettype wire

[rtl/upi_front.sv]
// Front end: twist products, angle wrapping into [-pi, pi] and quadrant fold.
`default_nettype none
`include "unicycle_pose_integrator_assert.svh"
module upi_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [31:0]                start_x,
	input  logic signed [31:0]                start_y,
	input  logic signed [15:0]                start_heading,
	input  logic signed [23:0]                linear_speed,
	input  logic signed [20:0]                turn_rate,
	input  logic [15:0]                       time_step,
	input  logic [19:0]                       rate_limit,
	output logic                              out_valid,
	output logic signed [upi_pkg::Z_W-1:0]    z_a,
	output logic signed [upi_pkg::Z_W-1:0]    z_b,
	output logic                              flip_a,
	output logic                              flip_b,
	output upi_pkg::trig_tag_t                tag
);
	typedef logic signed [upi_pkg::ANG_W-1:0] ang_t;

	localparam ang_t ANG_PI      = 38'sd3373259426;
	localparam ang_t ANG_HALF_PI = 38'sd1686629713;
	localparam ang_t TWO_PI_X1   = 38'sd6746518852;
	localparam ang_t TWO_PI_X2   = 38'sd13493037704;
	localparam ang_t TWO_PI_X4   = 38'sd26986075408;
	localparam ang_t HEAD_RND    = 38'sd65536;
	localparam logic signed [upi_pkg::Z_W-1:0] HALF_PI_Z = 33'sd1686629713;

	// Removes m full turns when that keeps the angle above -pi (or adds them
	// when that keeps it below pi), so three steps cover up to seven turns.
	function automatic ang_t wrap_step(input ang_t a, input ang_t m2pi);
		ang_t r;
		if ((a - m2pi) > -ANG_PI) begin
			r = a - m2pi;
		end else if ((a + m2pi) < ANG_PI) begin
			r = a + m2pi;
		end else begin
			r = a;
		end
		return r;
	endfunction

	logic [upi_pkg::DEN_W-1:0] w_abs;
	logic signed [37:0]        wdt;
	logic signed [40:0]        vdt;
	ang_t                      h30;
	upi_pkg::trig_tag_t        tag_c;

	assign w_abs = turn_rate[20] ? (~turn_rate + 21'd1) : turn_rate;
	assign wdt   = turn_rate * $signed({1'b0, time_step});
	assign vdt   = linear_speed * $signed({1'b0, time_step});
	assign h30   = {{5{start_heading[15]}}, start_heading, 17'd0};

	always_comb begin
		tag_c             = '0;
		tag_c.x0          = start_x;
		tag_c.y0          = start_y;
		tag_c.h           = start_heading;
		tag_c.v           = linear_speed;
		tag_c.aw          = w_abs;
		tag_c.w_neg       = turn_rate[20];
		tag_c.straight    = (w_abs < {1'b0, rate_limit}) || (turn_rate == 21'sd0);
		tag_c.travel      = vdt[40:8];
	end

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	ang_t               a_s1, b_s1, a_s2, b_s2, a_s3, b_s3, a_s4, b_s4;
	upi_pkg::trig_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [upi_pkg::Z_W-1:0] za_s5, zb_s5;
	logic               fa_s5, fb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= h30;
		b_s1   <= h30 + (wdt >>> 2);
		tag_s1 <= tag_c;
		a_s2   <= wrap_step(a_s1, TWO_PI_X4);
		b_s2   <= wrap_step(b_s1, TWO_PI_X4);
		tag_s2 <= tag_s1;
		a_s3   <= wrap_step(a_s2, TWO_PI_X2);
		b_s3   <= wrap_step(b_s2, TWO_PI_X2);
		tag_s3 <= tag_s2;
		a_s4   <= wrap_step(a_s3, TWO_PI_X1);
		b_s4   <= wrap_step(b_s3, TWO_PI_X1);
		tag_s4 <= tag_s3;
	end

	ang_t               a_fold, b_fold, b_head;
	logic               a_flip, b_flip;
	upi_pkg::trig_tag_t tag_f;

	// Fold into [-pi/2, pi/2]; the rotation result is negated later.
	always_comb begin
		a_flip = 1'b1;
		b_flip = 1'b1;
		if (a_s4 > ANG_HALF_PI) begin
			a_fold = a_s4 - ANG_PI;
		end else if (a_s4 < -ANG_HALF_PI) begin
			a_fold = a_s4 + ANG_PI;
		end else begin
			a_fold = a_s4;
			a_flip = 1'b0;
		end
		if (b_s4 > ANG_HALF_PI) begin
			b_fold = b_s4 - ANG_PI;
		end else if (b_s4 < -ANG_HALF_PI) begin
			b_fold = b_s4 + ANG_PI;
		end else begin
			b_fold = b_s4;
			b_flip = 1'b0;
		end
		b_head            = b_s4 + HEAD_RND;
		tag_f             = tag_s4;
		tag_f.heading_arc = b_head[32:17];
	end

	always_ff @(posedge clk) begin
		za_s5  <= a_fold[upi_pkg::Z_W-1:0];
		zb_s5  <= b_fold[upi_pkg::Z_W-1:0];
		fa_s5  <= a_flip;
		fb_s5  <= b_flip;
		tag_s5 <= tag_f;
	end

	assign out_valid = v_s5;
	assign z_a       = za_s5;
	assign z_b       = zb_s5;
	assign flip_a    = fa_s5;
	assign flip_b    = fb_s5;
	assign tag       = tag_s5;

	`UPI_ASSERT_IMP(a_fold_range, clk, arst_n, v_s5,
		za_s5 <= HALF_PI_Z && za_s5 >= -HALF_PI_Z && zb_s5 <= HALF_PI_Z && zb_s5 >= -HALF_PI_Z,
		"folded angle outside half turn")
endmodule
`default_nettype wire

[rtl/upi_cordic.sv]
// Two-lane pipelined rotation CORDIC giving sine and cosine scaled by 2^30.
`default_nettype none
`include "unicycle_pose_integrator_assert.svh"
module upi_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [upi_pkg::Z_W-1:0]    z_a,
	input  logic signed [upi_pkg::Z_W-1:0]    z_b,
	input  logic                              flip_a,
	input  logic                              flip_b,
	input  upi_pkg::trig_tag_t                tag_in,
	output logic                              out_valid,
	output logic signed [upi_pkg::XY_W-1:0]   sin_a,
	output logic signed [upi_pkg::XY_W-1:0]   cos_a,
	output logic signed [upi_pkg::XY_W-1:0]   sin_b,
	output logic signed [upi_pkg::XY_W-1:0]   cos_b,
	output upi_pkg::trig_tag_t                tag_out
);
	localparam int N = upi_pkg::CORDIC_STEPS;
	localparam logic signed [upi_pkg::XY_W-1:0] GAIN = 33'sd652032874;
	localparam logic [31:0] ATAN_TAB [N] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	typedef struct packed {
		logic signed [upi_pkg::XY_W-1:0] x;
		logic signed [upi_pkg::XY_W-1:0] y;
		logic signed [upi_pkg::Z_W-1:0]  z;
	} rot_t;

	function automatic rot_t rot_step(input rot_t r, input int sh);
		rot_t o;
		logic signed [upi_pkg::XY_W-1:0] xs, ys;
		logic signed [upi_pkg::Z_W-1:0]  at;
		xs = $signed(r.x) >>> sh;
		ys = $signed(r.y) >>> sh;
		at = $signed({1'b0, ATAN_TAB[sh]});
		if ($signed(r.z) >= 0) begin
			o.x = $signed(r.x) - ys;
			o.y = $signed(r.y) + xs;
			o.z = $signed(r.z) - at;
		end else begin
			o.x = $signed(r.x) + ys;
			o.y = $signed(r.y) - xs;
			o.z = $signed(r.z) + at;
		end
		return o;
	endfunction

	rot_t               ra_s [1:N];
	rot_t               rb_s [1:N];
	logic [N:1]         fa_s, fb_s, vld_s;
	upi_pkg::trig_tag_t tag_s [1:N];
	rot_t               ra_in, rb_in;
	logic               vld_o;

	assign ra_in = '{x: GAIN, y: '0, z: z_a};
	assign rb_in = '{x: GAIN, y: '0, z: z_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_o <= 1'b0;
		end else begin
			vld_s <= {vld_s[N-1:1], in_valid};
			vld_o <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		ra_s[1]  <= rot_step(ra_in, 0);
		rb_s[1]  <= rot_step(rb_in, 0);
		fa_s[1]  <= flip_a;
		fb_s[1]  <= flip_b;
		tag_s[1] <= tag_in;
		for (int i = 1; i < N; i++) begin
			ra_s[i+1]  <= rot_step(ra_s[i], i);
			rb_s[i+1]  <= rot_step(rb_s[i], i);
			fa_s[i+1]  <= fa_s[i];
			fb_s[i+1]  <= fb_s[i];
			tag_s[i+1] <= tag_s[i];
		end
		sin_a   <= fa_s[N] ? -ra_s[N].y : ra_s[N].y;
		cos_a   <= fa_s[N] ? -ra_s[N].x : ra_s[N].x;
		sin_b   <= fb_s[N] ? -rb_s[N].y : rb_s[N].y;
		cos_b   <= fb_s[N] ? -rb_s[N].x : rb_s[N].x;
		tag_out <= tag_s[N];
	end

	assign out_valid = vld_o;

	`UPI_ASSERT_ALWAYS(a_cordic_latency, clk, arst_n,
		vld_o == $past(vld_s[N]),
		"cordic valid lost or invented")
	`UPI_ASSERT_IMP(a_cordic_converged, clk, arst_n, vld_s[N],
		$signed(ra_s[N].z) < 256 && $signed(ra_s[N].z) > -256 &&
		$signed(rb_s[N].z) < 256 && $signed(rb_s[N].z) > -256,
		"cordic residual angle too large")
endmodule
`default_nettype wire

[rtl/upi_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
`include "unicycle_pose_integrator_assert.svh"
module upi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [upi_pkg::NUM_W-1:0]     num_x,
	input  logic [upi_pkg::NUM_W-1:0]     num_y,
	input  logic [upi_pkg::DEN_W-1:0]     den,
	input  upi_pkg::div_tag_t             tag_in,
	output logic                          out_valid,
	output logic [upi_pkg::NUM_W-1:0]     quo_x,
	output logic [upi_pkg::NUM_W-1:0]     quo_y,
	output upi_pkg::div_tag_t             tag_out
);
	localparam int N  = upi_pkg::NUM_W;
	localparam int DW = upi_pkg::DEN_W;

	// Dividend bits shift out of the top of nq while quotient bits enter below.
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [N-1:0]  nq;
	} dv_t;

	function automatic dv_t div_step(input dv_t s, input logic [DW-1:0] d);
		dv_t       o;
		logic [DW:0] trial, diff;
		logic      ge;
		trial = {s.rem, s.nq[N-1]};
		diff  = trial - {1'b0, d};
		ge    = trial >= {1'b0, d};
		o.rem = ge ? diff[DW-1:0] : trial[DW-1:0];
		o.nq  = {s.nq[N-2:0], ge};
		return o;
	endfunction

	dv_t               dx_s [1:N];
	dv_t               dy_s [1:N];
	logic [DW-1:0]     d_s [1:N];
	upi_pkg::div_tag_t tag_s [1:N];
	logic [N:1]        vld_s;
	dv_t               dx_in, dy_in;

	assign dx_in = '{rem: '0, nq: num_x};
	assign dy_in = '{rem: '0, nq: num_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[N-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		dx_s[1]  <= div_step(dx_in, den);
		dy_s[1]  <= div_step(dy_in, den);
		d_s[1]   <= den;
		tag_s[1] <= tag_in;
		for (int i = 1; i < N; i++) begin
			dx_s[i+1]  <= div_step(dx_s[i], d_s[i]);
			dy_s[i+1]  <= div_step(dy_s[i], d_s[i]);
			d_s[i+1]   <= d_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[N];
	assign quo_x     = dx_s[N].nq;
	assign quo_y     = dy_s[N].nq;
	assign tag_out   = tag_s[N];

	`UPI_ASSERT_IMP(a_div_remainder, clk, arst_n, vld_s[N] && d_s[N] != '0,
		dx_s[N].rem < d_s[N] && dy_s[N].rem < d_s[N],
		"divider remainder not below divisor")
endmodule
`default_nettype wire

[rtl/unicycle_pose_integrator.sv]
// Top level of the fixed-point unicycle pose integrator.
//
//  Channel   Signals                                      Direction
//  --------  -------------------------------------------  ---------
//  command   start, busy, start_x .. time_step            in
//  result    done, end_x .. position_saturated            out
//  config    cfg_wr_en, cfg_wr_data (straight_rate_limit) in
//
// A transaction is accepted at each edge with start high; busy is always low,
// so a new pose update may enter in every cycle.
// Results appear in the order of their commands, which pass through the 5 front
// stages, the 30 CORDIC iterations plus an output stage, 3 product stages, the
// 44 quotient bits of the divider and the final saturation stage.
// Reset clears every valid bit and sets straight_rate_limit to 1.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "unicycle_pose_integrator_assert.svh"
module unicycle_pose_integrator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [15:0] start_heading,
	input  logic signed [23:0] linear_speed,
	input  logic signed [20:0] turn_rate,
	input  logic [15:0]        time_step,
	input  logic               cfg_wr_en,
	input  logic [19:0]        cfg_wr_data,
	output logic               done,
	output logic signed [31:0] end_x,
	output logic signed [31:0] end_y,
	output logic signed [15:0] end_heading,
	output logic               went_straight,
	output logic               position_saturated
);
	localparam int XY_W  = upi_pkg::XY_W;
	localparam int NUM_W = upi_pkg::NUM_W;
	localparam int DS_W  = upi_pkg::DS_W;
	localparam logic signed [65:0] STRAIGHT_RND = 66'sd137438953472;
	localparam logic signed [45:0] POS_MAX      = 46'sd2147483647;
	localparam logic signed [45:0] POS_MIN      = -46'sd2147483648;
	localparam logic signed [15:0] HEAD_MAX     = 16'sd25736;

	// Threshold register; the user must write it only while the pipeline is empty, the block does not enforce it.
	logic [19:0] limit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 20'd1;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	assign busy = 1'b0;

	// Front end: products of the twist with the time step, start and end
	// angles wrapped and folded for the CORDIC.
	logic                           fr_valid, fr_flip_a, fr_flip_b;
	logic signed [upi_pkg::Z_W-1:0] fr_z_a, fr_z_b;
	upi_pkg::trig_tag_t             fr_tag;

	upi_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start),
		.start_x       (start_x),
		.start_y       (start_y),
		.start_heading (start_heading),
		.linear_speed  (linear_speed),
		.turn_rate     (turn_rate),
		.time_step     (time_step),
		.rate_limit    (limit_q),
		.out_valid     (fr_valid),
		.z_a           (fr_z_a),
		.z_b           (fr_z_b),
		.flip_a        (fr_flip_a),
		.flip_b        (fr_flip_b),
		.tag           (fr_tag)
	);

	// Lane a holds the start heading, lane b the heading after the turn.
	logic                    co_valid;
	logic signed [XY_W-1:0]  sin_a, cos_a, sin_b, cos_b;
	upi_pkg::trig_tag_t      co_tag;

	upi_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.z_a       (fr_z_a),
		.z_b       (fr_z_b),
		.flip_a    (fr_flip_a),
		.flip_b    (fr_flip_b),
		.tag_in    (fr_tag),
		.out_valid (co_valid),
		.sin_a     (sin_a),
		.cos_a     (cos_a),
		.sin_b     (sin_b),
		.cos_b     (cos_b),
		.tag_out   (co_tag)
	);

	// Stage 1: sine and cosine differences for the arc; distance times the
	// start direction for the straight step.
	logic                  v_s1, v_s2, v_s3;
	logic signed [XY_W:0]  sd_s1, cd_s1;
	logic signed [65:0]    px_s1, py_s1;
	upi_pkg::trig_tag_t    tag_s1, tag_s2;

	always_ff @(posedge clk) begin
		sd_s1  <= {sin_b[XY_W-1], sin_b} - {sin_a[XY_W-1], sin_a};
		cd_s1  <= {cos_a[XY_W-1], cos_a} - {cos_b[XY_W-1], cos_b};
		px_s1  <= $signed(co_tag.travel) * cos_a;
		py_s1  <= $signed(co_tag.travel) * sin_a;
		tag_s1 <= co_tag;
	end

	// Stage 2: speed times the differences; straight deltas rounded half up
	// to Q16.16.
	logic signed [57:0]     nx_s2, ny_s2;
	logic signed [DS_W-1:0] dxs_s2, dys_s2;
	logic signed [65:0]     px_rnd, py_rnd;

	assign px_rnd = px_s1 + STRAIGHT_RND;
	assign py_rnd = py_s1 + STRAIGHT_RND;

	always_ff @(posedge clk) begin
		nx_s2  <= $signed(tag_s1.v) * sd_s1;
		ny_s2  <= $signed(tag_s1.v) * cd_s1;
		dxs_s2 <= px_rnd[65:38];
		dys_s2 <= py_rnd[65:38];
		tag_s2 <= tag_s1;
	end

	// Stage 3: rounding half away from zero is done on magnitudes. Adding
	// half the divisor (|w| * 2^13) and dropping 14 bits leaves a plain
	// floor division by |w|.
	logic [57:0]            ax, ay, rx, ry;
	logic [NUM_W-1:0]       num_x_s3, num_y_s3;
	logic [upi_pkg::DEN_W-1:0] den_s3;
	upi_pkg::div_tag_t      dtag_c, dtag_s3;

	always_comb begin
		ax = nx_s2[57] ? 58'(-nx_s2) : 58'(nx_s2);
		ay = ny_s2[57] ? 58'(-ny_s2) : 58'(ny_s2);
		rx = ax + {24'd0, tag_s2.aw, 13'd0};
		ry = ay + {24'd0, tag_s2.aw, 13'd0};
		dtag_c.x0          = tag_s2.x0;
		dtag_c.y0          = tag_s2.y0;
		dtag_c.h           = tag_s2.h;
		dtag_c.heading_arc = tag_s2.heading_arc;
		dtag_c.straight    = tag_s2.straight;
		dtag_c.dxs         = dxs_s2;
		dtag_c.dys         = dys_s2;
		dtag_c.neg_x       = nx_s2[57] ^ tag_s2.w_neg;
		dtag_c.neg_y       = ny_s2[57] ^ tag_s2.w_neg;
	end

	always_ff @(posedge clk) begin
		num_x_s3 <= rx[57:14];
		num_y_s3 <= ry[57:14];
		den_s3   <= tag_s2.aw;
		dtag_s3  <= dtag_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= co_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// The quotient is only used on the arc path; on the straight path, where the
	// divisor may be zero, its value does not matter.
	logic               dv_valid;
	logic [NUM_W-1:0]   quo_x, quo_y;
	upi_pkg::div_tag_t  dv_tag;

	upi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.num_x     (num_x_s3),
		.num_y     (num_y_s3),
		.den       (den_s3),
		.tag_in    (dtag_s3),
		.out_valid (dv_valid),
		.quo_x     (quo_x),
		.quo_y     (quo_y),
		.tag_out   (dv_tag)
	);

	// Final stage: pick the delta, add it to the start position, saturate.
	logic signed [45:0] qx, qy, delta_x, delta_y, sum_x, sum_y;
	logic signed [31:0] sat_x, sat_y;
	logic               clip_x, clip_y;

	always_comb begin
		qx = $signed({2'b00, quo_x});
		qy = $signed({2'b00, quo_y});
		if (dv_tag.straight) begin
			delta_x = 46'(dv_tag.dxs);
			delta_y = 46'(dv_tag.dys);
		end else begin
			delta_x = dv_tag.neg_x ? -qx : qx;
			delta_y = dv_tag.neg_y ? -qy : qy;
		end
		sum_x  = 46'(dv_tag.x0) + delta_x;
		sum_y  = 46'(dv_tag.y0) + delta_y;
		clip_x = (sum_x > POS_MAX) || (sum_x < POS_MIN);
		clip_y = (sum_y > POS_MAX) || (sum_y < POS_MIN);
		if (sum_x > POS_MAX) begin
			sat_x = POS_MAX[31:0];
		end else if (sum_x < POS_MIN) begin
			sat_x = POS_MIN[31:0];
		end else begin
			sat_x = sum_x[31:0];
		end
		if (sum_y > POS_MAX) begin
			sat_y = POS_MAX[31:0];
		end else if (sum_y < POS_MIN) begin
			sat_y = POS_MIN[31:0];
		end else begin
			sat_y = sum_y[31:0];
		end
	end

	logic               done_q, straight_q, sat_q;
	logic signed [31:0] end_x_q, end_y_q;
	logic signed [15:0] heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		end_x_q    <= sat_x;
		end_y_q    <= sat_y;
		heading_q  <= dv_tag.straight ? dv_tag.h : dv_tag.heading_arc;
		straight_q <= dv_tag.straight;
		sat_q      <= clip_x || clip_y;
	end

	assign done               = done_q;
	assign end_x              = end_x_q;
	assign end_y              = end_y_q;
	assign end_heading        = heading_q;
	assign went_straight      = straight_q;
	assign position_saturated = sat_q;

	`UPI_ASSERT_IMP(a_arc_heading_range, clk, arst_n, done_q && !straight_q,
		heading_q <= HEAD_MAX && heading_q >= -HEAD_MAX,
		"arc heading outside half turn")
	`UPI_ASSERT_IMP(a_sat_at_limit, clk, arst_n, done_q && sat_q,
		end_x_q == POS_MAX[31:0] || end_x_q == POS_MIN[31:0] ||
		end_y_q == POS_MAX[31:0] || end_y_q == POS_MIN[31:0],
		"saturation flagged without a clipped position")
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the fixed-point unicycle pose integrator.
`timescale 1ns / 1ps

module testbench;
	// One pose update command and the pose it should produce.
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] h;
		logic signed [23:0] v;
		logic signed [20:0] w;
		logic [15:0]        dt;
	} pose_cmd_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] h;
		logic               straight;
		logic               sat;
	} pose_res_t;

	// A directed row; when typed is set the listed pose is the expectation,
	// otherwise the predictor supplies it.
	typedef struct {
		pose_cmd_t cmd;
		bit        typed;
		pose_res_t res;
	} pose_row_t;

	// Angle constants in radians scaled by 2^30.
	localparam longint ANGLE_PI      = 64'sd3373259426;
	localparam longint ANGLE_HALF_PI = 64'sd1686629713;
	localparam longint TRIG_GAIN     = 64'sd652032874;
	localparam int     TRIG_ITERS    = 30;
	localparam longint POS_HI        = 64'sd2147483647;
	localparam longint POS_LO        = -64'sd2147483648;
	localparam int     PIPE_LATENCY  = 84;

	localparam longint ARCTAN [TRIG_ITERS] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [15:0] start_heading;
	logic signed [23:0] linear_speed;
	logic signed [20:0] turn_rate;
	logic [15:0]        time_step;
	logic               cfg_wr_en;
	logic [19:0]        cfg_wr_data;
	logic               done;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic signed [15:0] end_heading;
	logic               went_straight;
	logic               position_saturated;

	// Model copy of straight_rate_limit; only changed while the pipe is empty.
	logic [19:0] rate_limit;
	pose_res_t   pending_poses[$];
	int          error_count;
	bit          idling_on;

	unicycle_pose_integrator u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.start_x           (start_x),
		.start_y           (start_y),
		.start_heading     (start_heading),
		.linear_speed      (linear_speed),
		.turn_rate         (turn_rate),
		.time_step         (time_step),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.done              (done),
		.end_x             (end_x),
		.end_y             (end_y),
		.end_heading       (end_heading),
		.went_straight     (went_straight),
		.position_saturated(position_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous hard limit; a correct run ends long before it.
	initial begin
		#20ms;
		$display("testbench: done, errors");
		$finish;
	end

	// Bring any angle back into [-pi, pi] by whole turns.
	function automatic longint wrap_to_pi(input longint a);
		longint r;
		r = a;
		while (r > ANGLE_PI) r -= 2 * ANGLE_PI;
		while (r < -ANGLE_PI) r += 2 * ANGLE_PI;
		return r;
	endfunction

	// Rotation-mode CORDIC after folding into [-pi/2, pi/2]; all shifts floor.
	task automatic rotate_unit(input longint angle, output longint sin_v,
			output longint cos_v);
		longint px, py, pz, sx, sy;
		bit     mirrored;
		px = TRIG_GAIN;
		py = 0;
		mirrored = 1'b0;
		pz = wrap_to_pi(angle);
		if (pz > ANGLE_HALF_PI) begin
			pz -= ANGLE_PI;
			mirrored = 1'b1;
		end else if (pz < -ANGLE_HALF_PI) begin
			pz += ANGLE_PI;
			mirrored = 1'b1;
		end
		for (int i = 0; i < TRIG_ITERS; i++) begin
			sx = px >>> i;
			sy = py >>> i;
			if (pz >= 0) begin
				px -= sy;
				py += sx;
				pz -= ARCTAN[i];
			end else begin
				px += sy;
				py -= sx;
				pz += ARCTAN[i];
			end
		end
		sin_v = mirrored ? -py : py;
		cos_v = mirrored ? -px : px;
	endtask

	// Division rounded half away from zero.
	function automatic longint quotient_rounded(input longint n, input longint d);
		longint an, ad, q;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = (an + ad / 2) / ad;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic logic signed [31:0] clip_position(input longint p,
			inout logic clipped);
		if (p > POS_HI) begin
			clipped = 1'b1;
			return POS_HI[31:0];
		end
		if (p < POS_LO) begin
			clipped = 1'b1;
			return POS_LO[31:0];
		end
		return p[31:0];
	endfunction

	// Expected end pose for one command under the current rate limit.
	task automatic advance_pose(input pose_cmd_t c, output pose_res_t r);
		longint w, v, dt, aw, h30, travel, s0, c0, s1, c1, a1, dx, dy, hd;
		logic   clipped;
		w = longint'(c.w);
		v = longint'(c.v);
		dt = longint'({1'b0, c.dt});
		aw = (w < 0) ? -w : w;
		h30 = longint'(c.h) * 131072;
		clipped = 1'b0;
		r.straight = (aw < longint'({1'b0, rate_limit})) || (w == 0);
		if (r.straight) begin
			travel = (v * dt) >>> 8;
			rotate_unit(h30, s0, c0);
			dx = (travel * c0 + (64'sd1 <<< 37)) >>> 38;
			dy = (travel * s0 + (64'sd1 <<< 37)) >>> 38;
			hd = longint'(c.h);
		end else begin
			a1 = h30 + ((w * dt) >>> 2);
			rotate_unit(h30, s0, c0);
			rotate_unit(a1, s1, c1);
			dx = quotient_rounded(v * (s1 - s0), w * 16384);
			dy = quotient_rounded(v * (c0 - c1), w * 16384);
			hd = (wrap_to_pi(a1) + 65536) >>> 17;
		end
		r.x = clip_position(longint'(c.x) + dx, clipped);
		r.y = clip_position(longint'(c.y) + dy, clipped);
		r.h = hd[15:0];
		r.sat = clipped;
	endtask

	// Present one command and hold it until the block takes it.
	task automatic issue_pose(input pose_cmd_t c, input bit typed,
			input pose_res_t typed_res);
		pose_res_t r;
		start <= 1'b1;
		start_x <= c.x;
		start_y <= c.y;
		start_heading <= c.h;
		linear_speed <= c.v;
		turn_rate <= c.w;
		time_step <= c.dt;
		do @(posedge clk); while (busy);
		if (typed) begin
			r = typed_res;
		end else begin
			advance_pose(c, r);
		end
		pending_poses.push_back(r);
	endtask

	// Random gap between transactions; start is lowered only for a gap.
	task automatic maybe_pause();
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Lower start and wait until every expected pose has arrived.
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (pending_poses.size() != 0) @(posedge clk);
	endtask

	task automatic write_rate_limit(input logic [19:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rate_limit = value;
	endtask

	function automatic logic [31:0] pick_position();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_0000 + $urandom_range(0, 32'hFFFF);
			3: return 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
			default: return $urandom;
		endcase
	endfunction

	// Turn rates cluster near the threshold so both motion cases show up.
	function automatic logic [20:0] pick_turn_rate();
		logic [20:0] mag;
		case ($urandom_range(0, 9))
			0: return 21'd0;
			1: return 21'h10_0000;
			2: return 21'h0F_FFFF;
			3, 4: begin
				mag = 21'(rate_limit) + 21'($urandom_range(0, 4)) - 21'd2;
				return ($urandom_range(0, 1) != 0) ? -mag : mag;
			end
			default: return 21'($urandom);
		endcase
	endfunction

	function automatic pose_cmd_t random_pose();
		pose_cmd_t c;
		c.x = pick_position();
		c.y = pick_position();
		c.h = ($urandom_range(0, 7) == 0) ? 16'($urandom)
			: 16'($signed($urandom_range(0, 51472)) - 25736);
		c.v = ($urandom_range(0, 9) == 0)
			? (($urandom_range(0, 1) != 0) ? 24'h7F_FFFF : 24'h80_0000)
			: 24'($urandom);
		c.w = pick_turn_rate();
		c.dt = ($urandom_range(0, 9) == 0)
			? (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000)
			: 16'($urandom);
		return c;
	endfunction

	// Result checker: the block cannot be stalled, so every strobe is a result.
	always @(posedge clk) begin
		pose_res_t want;
		if (arst_n && done) begin
			if (pending_poses.size() == 0) begin
				$error("unexpected result transaction");
				error_count++;
			end else begin
				want = pending_poses.pop_front();
				if (end_x !== want.x) begin
					$error("end_x expected %0d actual %0d", want.x, end_x);
					error_count++;
				end
				if (end_y !== want.y) begin
					$error("end_y expected %0d actual %0d", want.y, end_y);
					error_count++;
				end
				if (end_heading !== want.h) begin
					$error("end_heading expected %0d actual %0d", want.h, end_heading);
					error_count++;
				end
				if (went_straight !== want.straight) begin
					$error("went_straight expected %0b actual %0b", want.straight,
						went_straight);
					error_count++;
				end
				if (position_saturated !== want.sat) begin
					$error("position_saturated expected %0b actual %0b", want.sat,
						position_saturated);
					error_count++;
				end
			end
		end
	end

	// Directed rows. Typed rows have exact answers: a zero twist leaves the
	// pose alone, and a straight step with zero speed keeps even a heading
	// that lies outside [-pi, pi].
	pose_row_t directed_rows[$];

	function automatic pose_row_t make_row(input logic [31:0] x, input logic [31:0] y,
			input logic [15:0] h, input logic [23:0] v, input logic [20:0] w,
			input logic [15:0] dt, input bit typed);
		pose_row_t r;
		r.cmd = '{x, y, h, v, w, dt};
		r.typed = typed;
		r.res = '{x, y, h, 1'b1, 1'b0};
		return r;
	endfunction

	initial begin
		logic [19:0] limits [5];
		int          phase_items;
		error_count = 0;
		rate_limit = 20'd1;
		idling_on = 1'b1;
		arst_n <= 1'b0;
		start <= 1'b0;
		start_x <= '0;
		start_y <= '0;
		start_heading <= '0;
		linear_speed <= '0;
		turn_rate <= '0;
		time_step <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;

		directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 1));
		directed_rows.push_back(make_row(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF,
			0, 0, 16'hFFFF, 1));
		directed_rows.push_back(make_row(32'h1234_5678, 32'hFEDC_BA98, 16'h8000,
			0, 0, 16'hFFFF, 1));
		directed_rows.push_back(make_row(32'h7FFF_FFFF, 0, 0, 24'h7F_FFFF, 0,
			16'hFFFF, 0));
		directed_rows.push_back(make_row(32'h8000_0000, 0, 16'sd25736, 24'h7F_FFFF, 0,
			16'hFFFF, 0));
		directed_rows.push_back(make_row(0, 32'h7FFF_FFFF, 16'sd12868, 24'h7F_FFFF,
			0, 16'hFFFF, 0));
		directed_rows.push_back(make_row(0, 32'h8000_0000, -16'sd12868, 24'h7F_FFFF,
			0, 16'hFFFF, 0));
		directed_rows.push_back(make_row(0, 0, -16'sd25736, 24'h80_0000, 0,
			16'hFFFF, 0));
		directed_rows.push_back(make_row(0, 0, 0, 24'h01_0000, 21'h0F_FFFF,
			16'hFFFF, 0));
		directed_rows.push_back(make_row(0, 0, 0, 24'h01_0000, 21'h10_0000,
			16'hFFFF, 0));
		directed_rows.push_back(make_row(0, 0, 16'sd25736, 24'h7F_FFFF, 21'h01_0000,
			16'h8000, 0));
		directed_rows.push_back(make_row(0, 0, -16'sd25736, 24'h80_0000,
			21'h1F_0000, 16'h8000, 0));
		directed_rows.push_back(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
			24'h7F_FFFF, 21'h00_0001, 16'hFFFF, 0));
		directed_rows.push_back(make_row(32'h8000_0000, 32'h8000_0000, 16'h7FFF,
			24'h80_0000, 21'h1F_FFFF, 16'hFFFF, 0));
		directed_rows.push_back(make_row(32'h0001_0000, 32'hFFFF_0000, 16'h8000,
			24'h00_0001, 21'h05_5555, 16'h0001, 0));
		directed_rows.push_back(make_row(32'hAAAA_AAAA, 32'h5555_5555, 16'h5555,
			24'hAA_AAAA, 21'h0A_AAAA, 16'hAAAA, 0));
		directed_rows.push_back(make_row(32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA,
			24'h55_5555, 21'h15_5555, 16'h5555, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			issue_pose(directed_rows[i].cmd, directed_rows[i].typed,
				directed_rows[i].res);
			maybe_pause();
		end

		// Each phase starts from an empty pipe with a new threshold; the
		// final phase runs at full rate with no gaps.
		limits = '{20'd0, 20'hF_FFFF, 20'($urandom_range(1, 20'hF_FFFE)),
			20'h1_0000, 20'd1};
		foreach (limits[p]) begin
			drain_pipe();
			write_rate_limit(limits[p]);
			if (p == 4) idling_on = 1'b0;
			phase_items = (p == 4) ? 300 : 300;
			repeat (phase_items) begin
				issue_pose(random_pose(), 1'b0, '{0, 0, 0, 0, 0});
				maybe_pause();
			end
		end

		start <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 16) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/upi_pkg.sv
rtl/upi_front.sv
rtl/upi_cordic.sv
rtl/upi_div.sv
rtl/unicycle_pose_integrator.sv
tb/testbench.sv
